/* hw/rtl/msc_pkg.sv */
// Package: shared types, constants and state codes of the counted merge sort core.
package msc_pkg;
	localparam int unsigned DefMaxElements = 64;
	localparam int unsigned CountW = 10;
	localparam logic [CountW-1:0] CountLimit = 10'd1023;
	localparam int unsigned StackDepth = 7;

	typedef struct packed {
		logic signed [31:0] element;
		logic final_element;
	} in_word_t;

	typedef struct packed {
		logic signed [31:0] sorted_value;
		logic run_end;
		logic [CountW-1:0] compare_total;
		logic [CountW-1:0] move_total;
		logic overflowed;
	} out_word_t;

	typedef enum logic [3:0] {
		ST_LOAD, ST_START, ST_SPLIT, ST_MRA, ST_MRB, ST_MWR, ST_CRD, ST_CWR,
		ST_EMIT_RD, ST_EMIT
	} msc_state_t;

	typedef enum logic [1:0] {
		PH_LEFT, PH_RIGHT, PH_MERGE
	} msc_phase_t;
endpackage

/* hw/rtl/msc_mem.sv */
// Memory: one-port-write, one-port-read synchronous RAM with registered read data.
module msc_mem import msc_pkg::*; #(
	parameter int unsigned DEPTH = DefMaxElements,
	parameter int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic clk,
	input  logic we,
	input  logic [AW-1:0] waddr,
	input  logic [31:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [31:0] rdata
);
	logic [31:0] mem [DEPTH];
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

/* hw/rtl/merge_sort_counted_core.sv */
// Top level: counted merge sort core, load, sort and emit of one set of words.
//  channel | dir | payload    | handshake
//  in      | in  | in_word_t  | in_valid / in_ready
//  out     | out | out_word_t | out_valid / out_ready
// Load: one word per cycle; in_ready stays low from the final word until the last
// result word is taken. Sort: a range stack walks the split tree top down; each range
// of two or more words passes through left, right and merge steps. Each merge reads
// both heads and writes the taken word to scratch (MRA, MRB, MWR), then copies the
// range back (CRD, CWR), one RAM port each. Emit: read each word, hold it until taken.
// Reset clears control and counters; RAM and stack contents need none.
module merge_sort_counted_core import msc_pkg::*; #(
	parameter int unsigned MAX_ELEMENTS = DefMaxElements
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  in_word_t in_word,
	output logic out_valid,
	input  logic out_ready,
	output out_word_t out_word
);
	localparam int unsigned AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
	localparam int unsigned NW = $clog2(MAX_ELEMENTS + 1);
	localparam int unsigned PW = AW + 1;
	localparam int unsigned SW = $clog2(StackDepth + 1);

	msc_state_t state_q, state_d;
	logic [NW-1:0] cnt_q;
	logic ovf_q;
	logic [CountW-1:0] cmp_q, mov_q;
	logic [PW-1:0] lo_q, mid_q, hi_q, a_q, b_q, k_q;
	logic signed [31:0] av_q;
	logic [PW-1:0] n_x;

	logic [SW-1:0] sp_q, top_i;
	logic [AW-1:0] stk_lo_q [StackDepth];
	logic [AW-1:0] stk_hi_q [StackDepth];
	msc_phase_t stk_ph_q [StackDepth];
	logic [AW-1:0] top_lo, top_hi, top_mid;
	logic [AW:0] span_sum;
	msc_phase_t top_ph;
	logic push_left, push_right;

	logic s_we, t_we;
	logic [AW-1:0] s_wa, s_ra, t_wa, t_ra;
	logic [31:0] s_wd, s_rd, t_wd, t_rd;

	msc_mem #(.DEPTH(MAX_ELEMENTS), .AW(AW)) u_store (
		.clk(clk), .we(s_we), .waddr(s_wa), .wdata(s_wd), .raddr(s_ra), .rdata(s_rd));
	msc_mem #(.DEPTH(MAX_ELEMENTS), .AW(AW)) u_scratch (
		.clk(clk), .we(t_we), .waddr(t_wa), .wdata(t_wd), .raddr(t_ra), .rdata(t_rd));

	assign n_x = PW'(cnt_q);

	assign top_i = sp_q - SW'(1);
	assign top_lo = stk_lo_q[top_i];
	assign top_hi = stk_hi_q[top_i];
	assign top_ph = stk_ph_q[top_i];
	assign span_sum = {1'b0, top_lo} + {1'b0, top_hi};
	assign top_mid = span_sum[AW:1];
	assign push_left = (top_lo < top_mid);
	assign push_right = ((top_mid + AW'(1)) < top_hi);

	logic a_ok, b_ok, take_a;
	assign a_ok = (a_q <= mid_q);
	assign b_ok = (b_q <= hi_q);
	// equal heads: right half first
	assign take_a = a_ok && (!b_ok || (av_q < $signed(s_rd)));

	function automatic logic [CountW-1:0] bump(input logic [CountW-1:0] c);
		return (c == CountLimit) ? c : c + CountW'(1);
	endfunction

	always_comb begin
		state_d = state_q;
		in_ready = 1'b0;
		out_valid = 1'b0;
		s_we = 1'b0; s_wa = '0; s_wd = '0; s_ra = '0;
		t_we = 1'b0; t_wa = '0; t_wd = '0; t_ra = '0;
		out_word = '0;
		case (state_q)
			ST_LOAD: begin
				in_ready = 1'b1;
				s_we = in_valid && (cnt_q < NW'(MAX_ELEMENTS));
				s_wa = cnt_q[AW-1:0];
				s_wd = in_word.element;
				if (in_valid && in_word.final_element) begin
					state_d = ST_START;
				end
			end
			ST_START: begin
				state_d = (cnt_q > NW'(1)) ? ST_SPLIT : ST_EMIT_RD;
			end
			ST_SPLIT: begin
				if (sp_q == '0) begin
					state_d = ST_EMIT_RD;
				end else if (top_ph == PH_MERGE) begin
					state_d = ST_MRA;
				end
			end
			ST_MRA: begin
				s_ra = a_q[AW-1:0];
				state_d = ST_MRB;
			end
			ST_MRB: begin
				s_ra = b_q[AW-1:0];
				state_d = ST_MWR;
			end
			ST_MWR: begin
				t_we = 1'b1;
				t_wa = k_q[AW-1:0];
				t_wd = take_a ? av_q : s_rd;
				state_d = (k_q == hi_q) ? ST_CRD : ST_MRA;
			end
			ST_CRD: begin
				t_ra = k_q[AW-1:0];
				state_d = ST_CWR;
			end
			ST_CWR: begin
				s_we = 1'b1;
				s_wa = k_q[AW-1:0];
				s_wd = t_rd;
				state_d = (k_q == hi_q) ? ST_SPLIT : ST_CRD;
			end
			ST_EMIT_RD: begin
				s_ra = k_q[AW-1:0];
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				out_valid = 1'b1;
				out_word.sorted_value = s_rd;
				out_word.run_end = (k_q == n_x - PW'(1));
				out_word.compare_total = out_word.run_end ? cmp_q : '0;
				out_word.move_total = out_word.run_end ? mov_q : '0;
				out_word.overflowed = ovf_q;
				s_ra = k_q[AW-1:0];
				if (out_ready) begin
					state_d = out_word.run_end ? ST_LOAD : ST_EMIT_RD;
				end
			end
			default: state_d = ST_LOAD;
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_START && cnt_q > NW'(1)) begin
			stk_lo_q[0] <= '0;
			stk_hi_q[0] <= AW'(cnt_q - NW'(1));
			stk_ph_q[0] <= PH_LEFT;
		end else if (state_q == ST_SPLIT && sp_q != '0) begin
			case (top_ph)
				PH_LEFT: begin
					stk_ph_q[top_i] <= PH_RIGHT;
					if (push_left) begin
						stk_lo_q[sp_q] <= top_lo;
						stk_hi_q[sp_q] <= top_mid;
						stk_ph_q[sp_q] <= PH_LEFT;
					end
				end
				PH_RIGHT: begin
					stk_ph_q[top_i] <= PH_MERGE;
					if (push_right) begin
						stk_lo_q[sp_q] <= top_mid + AW'(1);
						stk_hi_q[sp_q] <= top_hi;
						stk_ph_q[sp_q] <= PH_LEFT;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			cnt_q <= '0;
			ovf_q <= 1'b0;
			cmp_q <= '0;
			mov_q <= '0;
			lo_q <= '0;
			mid_q <= '0;
			hi_q <= '0;
			a_q <= '0;
			b_q <= '0;
			k_q <= '0;
			sp_q <= '0;
			av_q <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_LOAD: begin
					if (in_valid) begin
						if (cnt_q < NW'(MAX_ELEMENTS)) begin
							cnt_q <= cnt_q + NW'(1);
						end else begin
							ovf_q <= 1'b1;
						end
					end
				end
				ST_START: begin
					k_q <= '0;
					sp_q <= (cnt_q > NW'(1)) ? SW'(1) : '0;
				end
				ST_SPLIT: begin
					if (sp_q == '0) begin
						k_q <= '0;
					end else begin
						case (top_ph)
							PH_LEFT: begin
								if (push_left) begin
									sp_q <= sp_q + SW'(1);
								end
							end
							PH_RIGHT: begin
								if (push_right) begin
									sp_q <= sp_q + SW'(1);
								end
							end
							PH_MERGE: begin
								lo_q <= PW'(top_lo);
								mid_q <= PW'(top_mid);
								hi_q <= PW'(top_hi);
								a_q <= PW'(top_lo);
								b_q <= PW'(top_mid) + PW'(1);
								k_q <= PW'(top_lo);
								sp_q <= sp_q - SW'(1);
							end
							default: ;
						endcase
					end
				end
				ST_MRA: ;
				ST_MRB: begin
					av_q <= $signed(s_rd);
				end
				ST_MWR: begin
					if (a_ok && b_ok) begin
						cmp_q <= bump(cmp_q);
					end
					mov_q <= bump(mov_q);
					if (take_a) begin
						a_q <= a_q + PW'(1);
					end else begin
						b_q <= b_q + PW'(1);
					end
					if (k_q == hi_q) begin
						k_q <= lo_q;
					end else begin
						k_q <= k_q + PW'(1);
					end
				end
				ST_CRD: ;
				ST_CWR: begin
					mov_q <= bump(mov_q);
					if (k_q != hi_q) begin
						k_q <= k_q + PW'(1);
					end
				end
				ST_EMIT_RD: ;
				ST_EMIT: begin
					if (out_ready) begin
						if (k_q == n_x - PW'(1)) begin
							cnt_q <= '0;
							ovf_q <= 1'b0;
							cmp_q <= '0;
							mov_q <= '0;
							k_q <= '0;
						end else begin
							k_q <= k_q + PW'(1);
						end
					end
				end
				default: ;
			endcase
		end
	end

	a_no_in_out: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid)) else $error("in and out active together");
	a_cnt_cap: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= NW'(MAX_ELEMENTS)) else $error("load count beyond capacity");
	a_stack_cap: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= SW'(StackDepth)) else $error("range stack beyond depth");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_word))
		else $error("out word changed while waiting");
	a_end_clear: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && out_word.run_end |=> cnt_q == '0 && !ovf_q)
		else $error("set state not cleared");
endmodule

/* dv/msc_checker.sv */
// Checker: watches both channels, predicts sorted sets with counts, and compares results.
`timescale 1ns / 1ps
module msc_checker import msc_pkg::*; #(
	parameter int unsigned MAX_ELEMENTS = DefMaxElements
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic in_ready,
	input  in_word_t in_word,
	input  logic out_valid,
	input  logic out_ready,
	input  out_word_t out_word,
	output int fail_count,
	output int pending_words,
	output int sets_done,
	output int words_seen
);
	logic signed [31:0] set_vals [MAX_ELEMENTS];
	logic signed [31:0] scratch_vals [MAX_ELEMENTS];
	int unsigned set_len;
	logic set_over;
	logic [CountW-1:0] cmp_cnt, mov_cnt;
	out_word_t sorted_q[$];

	function automatic void bump(inout logic [CountW-1:0] c);
		if (c != CountLimit)
			c = c + CountW'(1);
	endfunction

	function automatic void merge_span(int lo, int mid, int hi);
		int a, b, k;
		a = lo;
		b = mid + 1;
		k = lo;
		while (a <= mid && b <= hi) begin
			bump(cmp_cnt);
			if (set_vals[a] < set_vals[b]) begin
				scratch_vals[k] = set_vals[a];
				a++;
			end else begin
				scratch_vals[k] = set_vals[b];
				b++;
			end
			bump(mov_cnt);
			k++;
		end
		while (a <= mid) begin
			scratch_vals[k] = set_vals[a];
			a++;
			k++;
			bump(mov_cnt);
		end
		while (b <= hi) begin
			scratch_vals[k] = set_vals[b];
			b++;
			k++;
			bump(mov_cnt);
		end
		for (k = lo; k <= hi; k++) begin
			set_vals[k] = scratch_vals[k];
			bump(mov_cnt);
		end
	endfunction

	function automatic void sort_span(int lo, int hi);
		int mid;
		if (lo >= hi)
			return;
		mid = (lo + hi) / 2;
		sort_span(lo, mid);
		sort_span(mid + 1, hi);
		merge_span(lo, mid, hi);
	endfunction

	function automatic void close_set();
		out_word_t w;
		cmp_cnt = '0;
		mov_cnt = '0;
		if (set_len > 1)
			sort_span(0, set_len - 1);
		for (int i = 0; i < set_len; i++) begin
			w.sorted_value = set_vals[i];
			w.run_end = (i == set_len - 1);
			w.compare_total = w.run_end ? cmp_cnt : '0;
			w.move_total = w.run_end ? mov_cnt : '0;
			w.overflowed = set_over;
			sorted_q.push_back(w);
		end
		set_len = 0;
		set_over = 0;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		out_word_t e;
		int errs;
		if (!arst_n) begin
			set_len = 0;
			set_over = 0;
			sorted_q.delete();
			fail_count <= 0;
			pending_words <= 0;
			sets_done <= 0;
			words_seen <= 0;
		end else begin
			errs = 0;
			if (out_valid && out_ready) begin
				words_seen <= words_seen + 1;
				if (sorted_q.size() == 0) begin
					$error("unexpected word: sorted_value %0d", out_word.sorted_value);
					errs++;
				end else begin
					e = sorted_q.pop_front();
					if (e.sorted_value !== out_word.sorted_value) begin
						$error("sorted_value exp %0d got %0d", e.sorted_value,
							out_word.sorted_value);
						errs++;
					end
					if (e.run_end !== out_word.run_end) begin
						$error("run_end exp %0d got %0d", e.run_end, out_word.run_end);
						errs++;
					end
					if (e.compare_total !== out_word.compare_total) begin
						$error("compare_total exp %0d got %0d", e.compare_total,
							out_word.compare_total);
						errs++;
					end
					if (e.move_total !== out_word.move_total) begin
						$error("move_total exp %0d got %0d", e.move_total,
							out_word.move_total);
						errs++;
					end
					if (e.overflowed !== out_word.overflowed) begin
						$error("overflowed exp %0d got %0d", e.overflowed,
							out_word.overflowed);
						errs++;
					end
				end
			end
			if (in_valid && in_ready) begin
				if (set_len < MAX_ELEMENTS) begin
					set_vals[set_len] = in_word.element;
					set_len++;
				end else
					set_over = 1;
				if (in_word.final_element) begin
					close_set();
					sets_done <= sets_done + 1;
				end
			end
			fail_count <= fail_count + errs;
			pending_words <= sorted_q.size();
		end
	end
endmodule

/* dv/tb.sv */
// Testbench top: drives sets of words into the merge sort core and gives the verdict.
`timescale 1ns / 1ps
module tb import msc_pkg::*; ();

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_ready;
	in_word_t in_word = '0;
	logic out_valid;
	logic out_ready = 0;
	out_word_t out_word;
	int fail_count, pending_words, sets_done, words_seen;
	int items_sent = 0;
	int out_idle = 0;
	bit hold_out = 0;
	bit stim_done = 0;

	always #5 clk = ~clk;

	merge_sort_counted_core u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_word(in_word),
		.out_valid(out_valid), .out_ready(out_ready), .out_word(out_word)
	);

	msc_checker u_chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_word(in_word),
		.out_valid(out_valid), .out_ready(out_ready), .out_word(out_word),
		.fail_count(fail_count), .pending_words(pending_words),
		.sets_done(sets_done), .words_seen(words_seen)
	);

	task automatic send_word(logic signed [31:0] v, logic fin);
		int gap;
		gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 12);
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1;
		in_word <= '{element: v, final_element: fin};
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		items_sent++;
	endtask

	function automatic logic signed [31:0] rand_value(int mode);
		case (mode)
			0: return $urandom_range(0, 7) - 4;
			1: return $urandom_range(0, 3) == 0 ? 32'sh7fffffff : 32'sh80000000;
			default: return $urandom();
		endcase
	endfunction

	task automatic send_set(int len, int mode);
		for (int i = 0; i < len; i++)
			send_word(rand_value(mode), i == len - 1);
	endtask

	initial begin
		int len;
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// directed: single word, extremes, ties, sorted and reverse runs
		send_word(32'sh80000000, 1);
		send_word(32'sh7fffffff, 0);
		send_word(32'sh80000000, 0);
		send_word(0, 0);
		send_word(-1, 1);
		send_set(4, 0);
		for (int i = 0; i < 5; i++)
			send_word(i, i == 4);
		for (int i = 0; i < 6; i++)
			send_word(10 - i, i == 5);
		// overflow with the dropped word ending the set, then a full set
		send_set(67, 2);
		send_set(64, 1);
		while (items_sent < 300) begin
			len = $urandom_range(0, 9) == 0 ? $urandom_range(30, 70) :
				$urandom_range(1, 12);
			send_set(len, $urandom_range(0, 2));
		end
		in_valid <= 0;
		stim_done = 1;
	end

	initial begin
		wait (sets_done >= 3);
		@(posedge clk);
		hold_out <= 1;
		repeat (400) @(posedge clk);
		hold_out <= 0;
	end

	always @(posedge clk) begin
		int d;
		if (!arst_n) begin
			out_ready <= 0;
			out_idle <= 0;
		end else begin
			d = out_idle;
			if (out_valid && out_ready)
				d = $urandom_range(0, 12);
			else if (d > 0)
				d = d - 1;
			out_idle <= d;
			out_ready <= !hold_out && d == 0;
		end
	end

	initial begin
		wait (stim_done);
		repeat (2) @(posedge clk);
		while (pending_words != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		$display("%0d input words in %0d sets, %0d sorted words checked", items_sent,
			sets_done, words_seen);
		if (fail_count == 0)
			$display("merge_sort_counted_core regression: pass");
		else
			$display("merge_sort_counted_core regression: fail");
		$finish;
	end

	initial begin
		#20ms;
		$display("merge_sort_counted_core regression: fail");
		$finish;
	end
endmodule
